@@ design/ffba_pkg.sv @@
// Shared types and constants for the first-fit byte allocator.
// Holds the sequencer states, request and status codes and the result record.
// No dependencies.
`timescale 1ns / 1ps

package ffba_pkg;

  localparam logic [2:0] REQ_ALLOC   = 3'd0;
  localparam logic [2:0] REQ_FREE    = 3'd1;
  localparam logic [2:0] REQ_REALLOC = 3'd2;
  localparam logic [2:0] REQ_LOOKUP  = 3'd3;
  localparam logic [2:0] REQ_COMPACT = 3'd4;

  localparam logic [1:0] STAT_OK           = 2'd0;
  localparam logic [1:0] STAT_NO_MEMORY    = 2'd1;
  localparam logic [1:0] STAT_INVALID_FREE = 2'd2;
  localparam logic [1:0] STAT_NO_HANDLE    = 2'd3;

  localparam int MAX_RESULTS = 32;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_DISP,
    S_BO_CHK,
    S_BO_LEN,
    S_CLRB,
    S_FF_START,
    S_FF,
    S_PLACE,
    S_NEWH,
    S_SW_START,
    S_SW,
    S_LK,
    S_EMIT,
    S_CP_RD,
    S_CP_EV,
    S_CP_NEW,
    S_CP_WR0,
    S_CP_WR1,
    S_CP_NEXT,
    S_CP_OCC
  } state_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] handle;
    logic [7:0] addr;
    logic       anull;
    logic       is_move;
    logic [7:0] src;
    logic [7:0] dst;
    logic [7:0] len;
    logic       last;
  } res_t;

  function automatic res_t res_plain(input logic [1:0] st);
    res_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

endpackage

@@ design/ffba_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// A read at the address being written returns the old contents.
// No dependencies.
`timescale 1ns / 1ps

module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/first_fit_byte_allocator.sv @@
// Top level of the first-fit byte allocator with compaction.
// Depends on ffba_pkg and ffba_ram (occupancy, block start, length and handle memories).
//
//   channel  signals                                         direction
//   request  in_valid in_ready req_type handle_in size_in    in
//            null_after_free
//   result   out_valid out_ready status handle_out           out
//            address_out address_null is_move move_src
//            move_dst move_len last
//
// Alloc scans the occupancy memory one cell per cycle, then writes header plus
// payload cells one per cycle. Free and realloc of a live handle add a clear pass
// over the old block; a realloc that places its new block, and a free that nulls
// handles, add a sweep of one handle per cycle over made handles.
// Compact walks the arena for block starts, moves each live block down with a handle sweep, then rewrites occupancy.
// After reset a clearing pass over the occupancy and start memories runs before the first request.
// A waiting result does not block request acceptance; the sequencer stalls only when its next result is ready.
`timescale 1ns / 1ps

module first_fit_byte_allocator #(
  parameter int ARENA_BYTES  = 256,
  parameter int HANDLE_SLOTS = 32,
  parameter int HEADER_BYTES = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] req_type,
  input  logic [4:0] handle_in,
  input  logic [7:0] size_in,
  input  logic       null_after_free,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [4:0] handle_out,
  output logic [7:0] address_out,
  output logic       address_null,
  output logic       is_move,
  output logic [7:0] move_src,
  output logic [7:0] move_dst,
  output logic [7:0] move_len,
  output logic       last
);

  import ffba_pkg::*;

  localparam int AW = $clog2(ARENA_BYTES);
  localparam int HW = $clog2(HANDLE_SLOTS);
  localparam int MW = $clog2(HANDLE_SLOTS + 1);
  localparam int NW = $clog2(256 + HEADER_BYTES);
  localparam int XW = ((AW > NW) ? AW : NW) + 1;
  localparam logic [AW-1:0] LAST_A  = AW'(ARENA_BYTES - 1);
  localparam logic [AW-1:0] HDR_A   = AW'(HEADER_BYTES);
  localparam logic [NW-1:0] HDR_N   = NW'(HEADER_BYTES);
  localparam logic [XW-1:0] HDR_X   = XW'(HEADER_BYTES);
  localparam logic [XW-1:0] ARENA_X = XW'(ARENA_BYTES);
  localparam logic [6:0]    HS_7    = 7'(HANDLE_SLOTS);
  localparam logic [5:0]    MAXR    = 6'(MAX_RESULTS);

  state_t state, state_next;
  logic [2:0] op, op_next;
  logic [4:0] hreq, hreq_next;
  logic [7:0] nreq, nreq_next;
  logic nl, nl_next;
  logic [AW-1:0] cnt, cnt_next;
  logic [NW-1:0] pc, pc_next;
  logic [NW-1:0] run, run_next;
  logic [AW-1:0] pb, pb_next;
  logic [7:0] pl, pl_next;
  logic [AW-1:0] s_reg, s_reg_next;
  logic [AW-1:0] a_reg, a_reg_next;
  logic [7:0] oldn, oldn_next;
  logic [XW-1:0] j, j_next;
  logic [5:0] k, k_next;
  logic pend, pend_next;
  logic restore, restore_next;
  logic relo, relo_next;
  logic kill, kill_next;
  logic emit_cp, emit_cp_next;
  logic [AW-1:0] from_a, from_a_next;
  logic [AW-1:0] to_a, to_a_next;
  logic [HW-1:0] hs, hs_next;
  logic [4:0] hnew, hnew_next;
  res_t res, res_next;
  res_t out_q, out_q_next;
  logic out_valid_next;
  logic [MW-1:0] made, made_next;
  logic [HANDLE_SLOTS-1:0] live, live_next;

  logic [AW-1:0] cell_raddr, cell_waddr;
  logic occ_we, occ_wd, st_we, st_wd, len_we;
  logic [7:0] len_wd;
  logic [HW-1:0] h_raddr, h_waddr;
  logic h_we;
  logic [AW-1:0] h_wd;
  logic occ_q, st_q;
  logic [7:0] len_q;
  logic [AW-1:0] ha_q;

  ffba_ram #(.WIDTH(1), .DEPTH(ARENA_BYTES)) u_occ (
    .clk(clk), .we(occ_we), .waddr(cell_waddr), .wdata(occ_wd),
    .raddr(cell_raddr), .rdata(occ_q)
  );
  ffba_ram #(.WIDTH(1), .DEPTH(ARENA_BYTES)) u_start (
    .clk(clk), .we(st_we), .waddr(cell_waddr), .wdata(st_wd),
    .raddr(cell_raddr), .rdata(st_q)
  );
  ffba_ram #(.WIDTH(8), .DEPTH(ARENA_BYTES)) u_len (
    .clk(clk), .we(len_we), .waddr(cell_waddr), .wdata(len_wd),
    .raddr(cell_raddr), .rdata(len_q)
  );
  ffba_ram #(.WIDTH(AW), .DEPTH(HANDLE_SLOTS)) u_haddr (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wd),
    .raddr(h_raddr), .rdata(ha_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      cnt       <= '0;
      out_valid <= 1'b0;
      made      <= '0;
      live      <= '0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
      made      <= made_next;
      live      <= live_next;
    end
    op      <= op_next;
    hreq    <= hreq_next;
    nreq    <= nreq_next;
    nl      <= nl_next;
    pc      <= pc_next;
    run     <= run_next;
    pb      <= pb_next;
    pl      <= pl_next;
    s_reg   <= s_reg_next;
    a_reg   <= a_reg_next;
    oldn    <= oldn_next;
    j       <= j_next;
    k       <= k_next;
    pend    <= pend_next;
    restore <= restore_next;
    relo    <= relo_next;
    kill    <= kill_next;
    emit_cp <= emit_cp_next;
    from_a  <= from_a_next;
    to_a    <= to_a_next;
    hs      <= hs_next;
    hnew    <= hnew_next;
    res     <= res_next;
    out_q   <= out_q_next;
  end

  always_comb begin
    logic [6:0] hx;
    logic [HW-1:0] hidx;
    logic hvalid, hlive, full, hit, match;
    logic [NW-1:0] need, run_inc;
    logic [XW-1:0] sf;
    logic [AW-1:0] bnew;
    logic [7:0] cp;

    state_next = state;
    op_next = op;
    hreq_next = hreq;
    nreq_next = nreq;
    nl_next = nl;
    cnt_next = cnt;
    pc_next = pc;
    run_next = run;
    pb_next = pb;
    pl_next = pl;
    s_reg_next = s_reg;
    a_reg_next = a_reg;
    oldn_next = oldn;
    j_next = j;
    k_next = k;
    pend_next = pend;
    restore_next = restore;
    relo_next = relo;
    kill_next = kill;
    emit_cp_next = emit_cp;
    from_a_next = from_a;
    to_a_next = to_a;
    hs_next = hs;
    hnew_next = hnew;
    res_next = res;
    out_q_next = out_q;
    out_valid_next = out_valid && !out_ready;
    made_next = made;
    live_next = live;

    in_ready = 1'b0;
    cell_raddr = cnt;
    cell_waddr = cnt;
    occ_we = 1'b0;
    occ_wd = 1'b0;
    st_we = 1'b0;
    st_wd = 1'b0;
    len_we = 1'b0;
    len_wd = oldn;
    h_raddr = hs;
    h_waddr = hs;
    h_we = 1'b0;
    h_wd = to_a;

    hx = {2'b00, hreq};
    hidx = HW'(hx);
    hvalid = (hx < 7'(made)) && (hx < HS_7);
    hlive = hvalid && live[hidx];
    full = 7'(made) >= HS_7;
    need = NW'(nreq) + HDR_N;
    run_inc = run + NW'(1);
    hit = !occ_q && (run_inc == need);
    sf = XW'(cnt) + XW'(1) - XW'(need);
    bnew = pb + HDR_A;
    cp = (oldn < nreq) ? oldn : nreq;
    match = live[hs] && (ha_q == from_a);

    unique case (state)
      S_CLR: begin
        occ_we = 1'b1;
        st_we = 1'b1;
        cnt_next = cnt + AW'(1);
        if (cnt == LAST_A) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_next = req_type;
          hreq_next = handle_in;
          nreq_next = size_in;
          nl_next = null_after_free;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        emit_cp_next = 1'b0;
        relo_next = 1'b0;
        restore_next = 1'b0;
        h_raddr = hidx;
        unique case (op) inside
          REQ_ALLOC, REQ_REALLOC: begin
            if (op == REQ_ALLOC || (hvalid && !hlive)) begin
              if (full) begin
                res_next = res_plain(STAT_NO_HANDLE);
                state_next = S_EMIT;
              end else begin
                state_next = S_FF_START;
              end
            end else if (!hlive) begin
              res_next = res_plain(STAT_INVALID_FREE);
              state_next = S_EMIT;
            end else begin
              state_next = S_BO_CHK;
            end
          end
          REQ_FREE: begin
            if (!hlive) begin
              res_next = res_plain(STAT_INVALID_FREE);
              state_next = S_EMIT;
            end else begin
              state_next = S_BO_CHK;
            end
          end
          REQ_LOOKUP: begin
            if (!hvalid) begin
              res_next = res_plain(STAT_NO_HANDLE);
              res_next.anull = 1'b1;
              state_next = S_EMIT;
            end else if (!hlive) begin
              res_next = res_plain(STAT_OK);
              res_next.handle = hreq;
              res_next.anull = 1'b1;
              state_next = S_EMIT;
            end else begin
              state_next = S_LK;
            end
          end
          REQ_COMPACT: begin
            cnt_next = '0;
            j_next = '0;
            k_next = '0;
            pend_next = 1'b0;
            state_next = S_CP_RD;
          end
          default: begin
            res_next = res_plain(STAT_OK);
            state_next = S_EMIT;
          end
        endcase
      end
      S_BO_CHK: begin
        a_reg_next = ha_q;
        s_reg_next = ha_q - HDR_A;
        cell_raddr = ha_q - HDR_A;
        if (XW'(ha_q) < HDR_X) begin
          res_next = res_plain(STAT_INVALID_FREE);
          state_next = S_EMIT;
        end else begin
          state_next = S_BO_LEN;
        end
      end
      S_BO_LEN: begin
        oldn_next = len_q;
        pc_next = '0;
        if (!st_q) begin
          res_next = res_plain(STAT_INVALID_FREE);
          state_next = S_EMIT;
        end else if (op == REQ_REALLOC) begin
          relo_next = 1'b1;
          if (full) begin
            res_next = res_plain(STAT_NO_HANDLE);
            state_next = S_EMIT;
          end else begin
            state_next = S_CLRB;
          end
        end else begin
          state_next = S_CLRB;
        end
      end
      S_CLRB: begin
        cell_waddr = s_reg + AW'(pc);
        occ_we = 1'b1;
        st_we = 1'b1;
        pc_next = pc + NW'(1);
        if (pc == NW'(oldn) + HDR_N - NW'(1)) begin
          if (relo) begin
            state_next = S_FF_START;
          end else if (nl) begin
            from_a_next = a_reg;
            kill_next = 1'b1;
            state_next = S_SW_START;
          end else begin
            res_next = res_plain(STAT_OK);
            res_next.addr = 8'(a_reg);
            state_next = S_EMIT;
          end
        end
      end
      S_FF_START: begin
        cell_raddr = '0;
        cnt_next = '0;
        run_next = '0;
        state_next = S_FF;
      end
      S_FF: begin
        cell_raddr = cnt + AW'(1);
        cnt_next = cnt + AW'(1);
        run_next = occ_q ? '0 : run_inc;
        pc_next = '0;
        if (hit && (sf + HDR_X < ARENA_X)) begin
          pb_next = AW'(sf);
          pl_next = nreq;
          restore_next = 1'b0;
          state_next = S_PLACE;
        end else if (hit || cnt == LAST_A) begin
          if (relo) begin
            pb_next = s_reg;
            pl_next = oldn;
            restore_next = 1'b1;
            state_next = S_PLACE;
          end else begin
            res_next = res_plain(STAT_NO_MEMORY);
            state_next = S_EMIT;
          end
        end
      end
      S_PLACE: begin
        cell_waddr = pb + AW'(pc);
        occ_we = 1'b1;
        occ_wd = 1'b1;
        st_wd = 1'b1;
        len_wd = pl;
        if (pc == '0) begin
          st_we = 1'b1;
          len_we = 1'b1;
        end
        pc_next = pc + NW'(1);
        if (pc == NW'(pl) + HDR_N - NW'(1)) begin
          if (restore) begin
            res_next = res_plain(STAT_NO_MEMORY);
            state_next = S_EMIT;
          end else begin
            state_next = S_NEWH;
          end
        end
      end
      S_NEWH: begin
        h_we = 1'b1;
        h_waddr = HW'(made);
        h_wd = bnew;
        live_next[HW'(made)] = 1'b1;
        made_next = made + MW'(1);
        hnew_next = 5'(made);
        if (relo) begin
          from_a_next = a_reg;
          to_a_next = bnew;
          kill_next = 1'b0;
          state_next = S_SW_START;
        end else begin
          res_next = res_plain(STAT_OK);
          res_next.handle = 5'(made);
          res_next.addr = 8'(bnew);
          state_next = S_EMIT;
        end
      end
      S_SW_START: begin
        h_raddr = '0;
        hs_next = '0;
        state_next = S_SW;
      end
      S_SW: begin
        if (match) begin
          if (kill) begin
            live_next[hs] = 1'b0;
          end else begin
            h_we = 1'b1;
          end
        end
        h_raddr = hs + HW'(1);
        hs_next = hs + HW'(1);
        if (MW'(hs) + MW'(1) == made) begin
          if (op == REQ_COMPACT) begin
            state_next = S_CP_NEXT;
          end else if (relo) begin
            res_next = res_plain(STAT_OK);
            res_next.handle = hnew;
            res_next.addr = 8'(to_a);
            if (to_a != from_a && cp != 8'd0) begin
              res_next.is_move = 1'b1;
              res_next.src = 8'(from_a);
              res_next.dst = 8'(to_a);
              res_next.len = cp;
            end
            state_next = S_EMIT;
          end else begin
            res_next = res_plain(STAT_OK);
            res_next.addr = 8'(from_a);
            state_next = S_EMIT;
          end
        end
      end
      S_LK: begin
        res_next = res_plain(STAT_OK);
        res_next.handle = hreq;
        res_next.addr = 8'(ha_q);
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          out_q_next = res;
          out_valid_next = 1'b1;
          state_next = emit_cp ? S_CP_NEW : S_IDLE;
        end
      end
      S_CP_RD: begin
        cell_raddr = cnt;
        state_next = S_CP_EV;
      end
      S_CP_EV: begin
        if (st_q) begin
          s_reg_next = cnt;
          oldn_next = len_q;
          if (k < MAXR) begin
            if (pend) begin
              emit_cp_next = 1'b1;
              state_next = S_EMIT;
            end else begin
              state_next = S_CP_NEW;
            end
          end else begin
            state_next = S_CP_WR0;
          end
        end else if (cnt == LAST_A) begin
          cnt_next = '0;
          state_next = S_CP_OCC;
        end else begin
          cell_raddr = cnt + AW'(1);
          cnt_next = cnt + AW'(1);
        end
      end
      S_CP_NEW: begin
        emit_cp_next = 1'b0;
        res_next = res_plain(STAT_OK);
        res_next.addr = 8'(j + HDR_X);
        res_next.is_move = 1'b1;
        res_next.src = 8'(s_reg + HDR_A);
        res_next.dst = 8'(j + HDR_X);
        res_next.len = oldn;
        res_next.last = 1'b0;
        pend_next = 1'b1;
        k_next = k + 6'd1;
        state_next = S_CP_WR0;
      end
      S_CP_WR0: begin
        cell_waddr = s_reg;
        st_we = 1'b1;
        state_next = S_CP_WR1;
      end
      S_CP_WR1: begin
        cell_waddr = AW'(j);
        st_we = 1'b1;
        st_wd = 1'b1;
        len_we = 1'b1;
        from_a_next = s_reg + HDR_A;
        to_a_next = AW'(j) + HDR_A;
        kill_next = 1'b0;
        state_next = S_SW_START;
      end
      S_CP_NEXT: begin
        j_next = j + HDR_X + XW'(oldn);
        if (s_reg == LAST_A) begin
          cnt_next = '0;
          state_next = S_CP_OCC;
        end else begin
          cnt_next = s_reg + AW'(1);
          state_next = S_CP_RD;
        end
      end
      S_CP_OCC: begin
        cell_waddr = cnt;
        occ_we = 1'b1;
        occ_wd = XW'(cnt) < j;
        cnt_next = cnt + AW'(1);
        if (cnt == LAST_A) begin
          emit_cp_next = 1'b0;
          if (pend) begin
            res_next.last = 1'b1;
          end else begin
            res_next = res_plain(STAT_OK);
          end
          state_next = S_EMIT;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign status       = out_q.status;
  assign handle_out   = out_q.handle;
  assign address_out  = out_q.addr;
  assign address_null = out_q.anull;
  assign is_move      = out_q.is_move;
  assign move_src     = out_q.src;
  assign move_dst     = out_q.dst;
  assign move_len     = out_q.len;
  assign last         = out_q.last;

`ifndef SYNTH
  a_made_bound: assert property (@(posedge clk) disable iff (rst)
    7'(made) <= HS_7)
    else $error("handle count beyond the table");

  a_k_bound: assert property (@(posedge clk) disable iff (rst)
    k <= MAXR)
    else $error("compact result count beyond the limit");

  a_accept_disp: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DISP))
    else $error("accepted request not dispatched");

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_valid && !out_ready) |=> (state == S_EMIT))
    else $error("result loaded over a waiting result");

  a_place_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_PLACE) |-> (XW'(pb) + XW'(pc) < ARENA_X))
    else $error("placement beyond the arena");
`endif

endmodule
